// ----- design/psl_pkg.sv -----
// ----------------------------------------------------------------------------
// psl_pkg - shared types and constants for the prime sieve lister
// Field widths, build size default, controller states and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

   localparam int LIMIT_W       = 9;    // width of limit and prime fields
   localparam int CUR_W         = 10;   // multiple cursor width
   localparam int MAX_LIMIT_DEF = 300;  // default build size
   localparam int FIRST_PRIME   = 2;    // smallest number sieved

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_BASE_RD,
      ST_BASE_CHK,
      ST_STRIKE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FINAL
   } psl_state_type;

   typedef struct packed {
      logic ld_lim;       // capture limit, clear pending prime, start clear sweep
      logic clr_step;     // set mark at cursor, advance cursor
      logic base_init;    // base = 2
      logic base_rd;      // read mark of base
      logic base_inc;     // advance base
      logic strike_init;  // cursor = 2 * base
      logic strike_step;  // clear mark at cursor, cursor += base
      logic scan_init;    // cursor = 2
      logic scan_rd;      // read mark at cursor
      logic scan_inc;     // advance cursor
      logic pend_set;     // hold cursor as pending prime
      logic emit_pend;    // send pending prime, not last
      logic emit_final;   // send pending prime as last, or none found
   } psl_cmd_type;

   typedef struct packed {
      logic clr_done;     // cursor at last mark of the store
      logic base_over;    // 2 * base above limit
      logic strike_done;  // cursor reached limit
      logic scan_last;    // cursor is limit - 1
      logic lim_small;    // limit of 2 or less
      logic rd_mark;      // registered mark read
      logic pend_valid;   // a prime is pending
      logic out_free;     // output register can take an item
   } psl_sts_type;

endpackage

`default_nettype wire

// ----- design/psl_req_if.sv -----
// ----------------------------------------------------------------------------
// psl_req_if - request channel
// Valid/ready channel carrying one sieve limit per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface psl_req_if;
   import psl_pkg::*;

   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] limit;

   modport source (output valid, output limit, input ready);
   modport sink   (input valid, input limit, output ready);
endinterface

`default_nettype wire

// ----- design/psl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// psl_rsp_if - result channel
// Valid/ready channel carrying one prime per item with last and none flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface psl_rsp_if;
   import psl_pkg::*;

   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] prime;
   logic               is_last;
   logic               none_found;

   modport source (output valid, output prime, output is_last, output none_found,
                   input ready);
   modport sink   (input valid, input prime, input is_last, input none_found,
                   output ready);
endinterface

`default_nettype wire

// ----- design/prime_sieve_lister.sv -----
// ----------------------------------------------------------------------------
// prime_sieve_lister - sieve of Eratosthenes prime lister
// Takes a limit per request item and returns every prime below it.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one limit per item; limits above MAX_LIMIT saturate to it.
//   rsp returns the primes below the limit in ascending order, one per item,
//   with is_last on the final one. With no prime below the limit a single
//   item comes back with prime 0, is_last and none_found set.
// Sequence, per request (L = saturated limit):
//   the item is taken, then every mark in the one-bit store is set (one
//   write port, one entry per cycle), then each base up to L/2 is read and
//   checked, and each base still marked has its multiples struck; the sieve
//   is left, each number from 2 to L-1 is read and checked, and the final
//   item is sent. The first result appears once the second prime is found
//   (or at the end of the scan).
// Handshake: req is ready only between requests; one request is processed at
//   a time. Results leave through an output register, so the next request can
//   be taken while the last result still waits. A stalled rsp holds the scan
//   until the pending prime can leave; nothing is dropped.
// Reset: synchronous, active high; returns to idle with no result pending.
//   The mark store needs no reset, every request rewrites it first.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sieve_lister #(
   parameter int MAX_LIMIT = psl_pkg::MAX_LIMIT_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   psl_req_if.sink   req,
   psl_rsp_if.source rsp
);
   import psl_pkg::*;

   psl_cmd_type cmd;
   psl_sts_type sts;

   // sequencer: phases and request handshake
   psl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // mark store, cursors and result register
   psl_dp #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_limit (req.limit),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ----- design/psl_ctrl.sv -----
// ----------------------------------------------------------------------------
// psl_ctrl - sieve sequencer
// State machine stepping through clear, sieve and scan phases; issues
// commands to the datapath and owns the request handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire psl_pkg::psl_sts_type sts,
   output psl_pkg::psl_cmd_type      cmd
);
   import psl_pkg::*;

   psl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            if (sts.clr_done) state_in = ST_BASE_RD;
         end
         ST_BASE_RD: begin
            if (!sts.base_over)    state_in = ST_BASE_CHK;
            else if (sts.lim_small) state_in = ST_FINAL;
            else                    state_in = ST_SCAN_RD;
         end
         ST_BASE_CHK: begin
            state_in = sts.rd_mark ? ST_STRIKE : ST_BASE_RD;
         end
         ST_STRIKE: begin
            if (sts.strike_done) state_in = ST_BASE_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!(sts.rd_mark && sts.pend_valid && !sts.out_free)) begin
               state_in = sts.scan_last ? ST_FINAL : ST_SCAN_RD;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.ld_lim = req_valid;
         end
         ST_CLEAR: begin
            cmd.clr_step  = 1'b1;
            cmd.base_init = sts.clr_done;
         end
         ST_BASE_RD: begin
            cmd.base_rd   = !sts.base_over;
            cmd.scan_init = sts.base_over;
         end
         ST_BASE_CHK: begin
            cmd.strike_init = sts.rd_mark;
            cmd.base_inc    = !sts.rd_mark;
         end
         ST_STRIKE: begin
            cmd.strike_step = !sts.strike_done;
            cmd.base_inc    = sts.strike_done;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
         end
         ST_SCAN_CHK: begin
            // hold while a pending prime cannot leave yet
            if (!(sts.rd_mark && sts.pend_valid && !sts.out_free)) begin
               cmd.pend_set  = sts.rd_mark;
               cmd.emit_pend = sts.rd_mark && sts.pend_valid;
               cmd.scan_inc  = 1'b1;
            end
         end
         ST_FINAL: begin
            cmd.emit_final = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/psl_dp.sv -----
// ----------------------------------------------------------------------------
// psl_dp - sieve datapath
// Mark store, base and multiple cursors, pending prime and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_dp #(
   parameter int MAX_LIMIT = psl_pkg::MAX_LIMIT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [psl_pkg::LIMIT_W-1:0] req_limit,
   input  wire psl_pkg::psl_cmd_type cmd,
   output psl_pkg::psl_sts_type      sts,
   psl_rsp_if.source                 rsp
);
   import psl_pkg::*;

   localparam int AW = $clog2(MAX_LIMIT);

   logic                mem [MAX_LIMIT];
   logic [LIMIT_W-1:0]  lim_ff, lim_in;
   logic [LIMIT_W-1:0]  base_ff, base_in;
   logic [CUR_W-1:0]    cursor_ff, cursor_in;
   logic                rd_mark_ff;
   logic [LIMIT_W-1:0]  pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]  rsp_prime_ff, rsp_prime_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_none_ff, rsp_none_in;
   logic                wr_en, wr_data, rd_en;
   logic [AW-1:0]       rd_addr;
   logic [CUR_W-1:0]    lim_ext, base_dbl;

   assign lim_ext  = {1'b0, lim_ff};
   assign base_dbl = {base_ff, 1'b0};

   // saturate limit to the build size
   assign lim_in = ({1'b0, req_limit} > CUR_W'(MAX_LIMIT)) ? LIMIT_W'(MAX_LIMIT)
                                                           : req_limit;

   always_comb begin
      base_in = base_ff;
      if (cmd.base_init)     base_in = LIMIT_W'(FIRST_PRIME);
      else if (cmd.base_inc) base_in = base_ff + LIMIT_W'(1);
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.ld_lim)                     cursor_in = '0;
      else if (cmd.clr_step || cmd.scan_inc) cursor_in = cursor_ff + CUR_W'(1);
      else if (cmd.strike_init)           cursor_in = base_dbl;
      else if (cmd.strike_step)           cursor_in = cursor_ff + {1'b0, base_ff};
      else if (cmd.scan_init)             cursor_in = CUR_W'(FIRST_PRIME);
   end

   assign wr_en   = cmd.clr_step || cmd.strike_step;
   assign wr_data = cmd.clr_step;
   assign rd_en   = cmd.base_rd || cmd.scan_rd;
   assign rd_addr = cmd.base_rd ? base_ff[AW-1:0] : cursor_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[cursor_ff[AW-1:0]] <= wr_data;
      if (rd_en) rd_mark_ff <= mem[rd_addr];
   end

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.ld_lim) begin
         pend_valid_in = 1'b0;
      end else if (cmd.pend_set) begin
         pend_in       = cursor_ff[LIMIT_W-1:0];
         pend_valid_in = 1'b1;
      end
   end

   // output register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_prime_in = rsp_prime_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;
      if (cmd.emit_pend) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = pend_ff;
         rsp_last_in  = 1'b0;
         rsp_none_in  = 1'b0;
      end else if (cmd.emit_final) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = pend_valid_ff ? pend_ff : '0;
         rsp_last_in  = 1'b1;
         rsp_none_in  = !pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_lim) lim_ff <= lim_in;
      base_ff      <= base_in;
      cursor_ff    <= cursor_in;
      pend_ff      <= pend_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_none_ff  <= rsp_none_in;
   end

   assign sts.clr_done    = (cursor_ff == CUR_W'(MAX_LIMIT - 1));
   assign sts.base_over   = (base_dbl > lim_ext);
   assign sts.strike_done = (cursor_ff >= lim_ext);
   assign sts.scan_last   = ((cursor_ff + CUR_W'(1)) >= lim_ext);
   assign sts.lim_small   = (lim_ff <= LIMIT_W'(FIRST_PRIME));
   assign sts.rd_mark     = rd_mark_ff;
   assign sts.pend_valid  = pend_valid_ff;
   assign sts.out_free    = !rsp_valid_ff || rsp.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.prime      = rsp_prime_ff;
   assign rsp.is_last    = rsp_last_ff;
   assign rsp.none_found = rsp_none_ff;

endmodule

`default_nettype wire
